>>> rtl/mp2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_pkg - shared types and constants for the 2-D max pooling block
// Register indexes, job and configuration structs, small divide helper.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    localparam int DEF_MAX_COLS     = 64;
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_WINDOW   = 4;

    localparam int Q_W        = 16;
    localparam int LIM_W      = 11;
    localparam int DIV_W      = 10;
    localparam int COL_FW     = 10;
    localparam int CHAN_FW    = 8;
    localparam int SLOT_FW    = 3;
    localparam int OUT_RC_W   = 6;
    localparam int OUT_CH_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam int RECIP3    = 683;
    localparam int RECIP3_SH = 11;

    localparam logic [Q_W-1:0] Q_MIN = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANS  = 3'd4;

    typedef struct packed {
        logic [2:0]       stride;
        logic [2:0]       win;
        logic [LIM_W-1:0] rows;
        logic [LIM_W-1:0] cols;
        logic [LIM_W-1:0] chans;
    } t_cfg;

    typedef struct packed {
        logic [Q_W-1:0]      sample;
        logic [COL_FW-1:0]   col;
        logic [CHAN_FW-1:0]  chan;
        logic [SLOT_FW-1:0]  slot;
        logic                fire;
        logic [OUT_RC_W-1:0] orow;
        logic [OUT_RC_W-1:0] ocol;
        logic                last;
    } t_job;

    typedef struct packed {
        logic [DIV_W-1:0] q;
        logic [1:0]       rem;
    } t_qr;

    // quotient and remainder for a divisor of 1 to 4
    function automatic t_qr div_small(input logic [DIV_W-1:0] a, input logic [2:0] s);
        t_qr                  res;
        logic [2*DIV_W:0]     prod;
        logic [DIV_W-1:0]     back3;
        prod    = (2*DIV_W+1)'(a) * (2*DIV_W+1)'(RECIP3);
        back3   = '0;
        res.q   = a;
        res.rem = 2'd0;
        case (s)
            3'd2: begin
                res.q   = a >> 1;
                res.rem = {1'b0, a[0]};
            end
            3'd3: begin
                res.q   = prod[RECIP3_SH +: DIV_W];
                back3   = DIV_W'({res.q, 1'b0} + {1'b0, res.q});
                res.rem = 2'(a - back3);
            end
            3'd4: begin
                res.q   = a >> 2;
                res.rem = a[1:0];
            end
            default: begin
                res.q   = a;
                res.rem = 2'd0;
            end
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mp2d_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_ram - generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/mp2d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_queue - two-entry job queue
// Decouples request intake from the line store sequencer.
// ----------------------------------------------------------------------------
module mp2d_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mp2d_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output mp2d_pkg::t_job     o_job,
    output logic               o_empty
);
    import mp2d_pkg::*;

    t_job       r_entry [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_entry[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? !r_wptr : r_wptr;
        n_rptr  = do_pop ? !r_rptr : r_rptr;
        n_count = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count lost a request");
`endif
endmodule
`default_nettype wire

>>> rtl/mp2d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_front - request intake and window classification
// Tracks row/column/channel position, flags window-completing requests.
// ----------------------------------------------------------------------------
module mp2d_front #(
    parameter int MAX_ROWS     = mp2d_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = mp2d_pkg::DEF_MAX_COLS,
    parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = mp2d_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mp2d_pkg::t_cfg               i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [mp2d_pkg::Q_W-1:0]     i_sample,
    input  wire logic                         i_full,
    output logic                              o_push,
    output mp2d_pkg::t_job                    o_job
);
    import mp2d_pkg::*;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CHAN_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CHAN_W-1:0] r_chan, n_chan;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic             accept;
    logic [LIM_W-1:0] w_l, rp1, cp1, chp1;
    logic             row_ok, col_ok, edge_ok, fire, last;
    t_qr              qr_r, qr_c, qr_lr, qr_lc;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        w_l     = LIM_W'(i_cfg.win);
        rp1     = LIM_W'(r_row) + LIM_W'(1);
        cp1     = LIM_W'(r_col) + LIM_W'(1);
        chp1    = LIM_W'(r_chan) + LIM_W'(1);
        row_ok  = (rp1 >= w_l);
        col_ok  = (cp1 >= w_l);
        edge_ok = (i_cfg.rows >= w_l) && (i_cfg.cols >= w_l);
        qr_r    = div_small(DIV_W'(rp1 - w_l), i_cfg.stride);
        qr_c    = div_small(DIV_W'(cp1 - w_l), i_cfg.stride);
        qr_lr   = div_small(DIV_W'(i_cfg.rows - w_l), i_cfg.stride);
        qr_lc   = div_small(DIV_W'(i_cfg.cols - w_l), i_cfg.stride);
        fire    = row_ok && col_ok && (qr_r.rem == 2'd0) && (qr_c.rem == 2'd0);
        last    = fire && edge_ok && (qr_r.q == qr_lr.q) && (qr_c.q == qr_lc.q)
                  && (chp1 == i_cfg.chans);

        o_job.sample = i_sample;
        o_job.col    = COL_FW'(r_col);
        o_job.chan   = CHAN_FW'(r_chan);
        o_job.slot   = SLOT_FW'(r_slot);
        o_job.fire   = fire;
        o_job.orow   = qr_r.q[OUT_RC_W-1:0];
        o_job.ocol   = qr_c.q[OUT_RC_W-1:0];
        o_job.last   = last;

        n_row  = r_row;
        n_col  = r_col;
        n_chan = r_chan;
        n_slot = r_slot;
        if (chp1 >= i_cfg.chans) begin
            n_chan = '0;
            if (cp1 >= i_cfg.cols) begin
                n_col = '0;
                if (rp1 >= i_cfg.rows) begin
                    n_row  = '0;
                    n_slot = '0;
                end else begin
                    n_row  = ROW_W'(rp1);
                    n_slot = (32'(r_slot) + 1 == MAX_WINDOW) ? '0 : r_slot + SLOT_W'(1);
                end
            end else begin
                n_col = COL_W'(cp1);
            end
        end else begin
            n_chan = CHAN_W'(chp1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_chan <= '0;
            r_slot <= '0;
        end else if (accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_chan <= n_chan;
            r_slot <= n_slot;
        end
    end

`ifndef SYNTHESIS
    a_last_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.last) |-> o_job.fire) else $error("last flag on non-result");
`endif
endmodule
`default_nettype wire

>>> rtl/mp2d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_back - line store sequencer
// Writes each element, sweeps the window on completion, holds the result.
// ----------------------------------------------------------------------------
module mp2d_back #(
    parameter int MAX_COLS     = mp2d_pkg::DEF_MAX_COLS,
    parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = mp2d_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mp2d_pkg::t_cfg                i_cfg,
    input  wire mp2d_pkg::t_job                i_job,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [mp2d_pkg::Q_W-1:0]           o_pooled,
    output logic [mp2d_pkg::OUT_RC_W-1:0]      o_out_row,
    output logic [mp2d_pkg::OUT_RC_W-1:0]      o_out_col,
    output logic [mp2d_pkg::OUT_CH_W-1:0]      o_channel_index,
    output logic                               o_final_res
);
    import mp2d_pkg::*;

    localparam int DEPTH  = MAX_WINDOW * MAX_COLS * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [SLOT_FW-1:0]  r_rs, n_rs;
    logic [COL_FW-1:0]   r_cc, n_cc;
    logic [COL_FW-1:0]   r_c0, n_c0;
    logic [2:0]          r_dr, n_dr;
    logic [2:0]          r_dc, n_dc;
    logic [CHAN_FW-1:0]  r_ch, n_ch;
    logic [OUT_RC_W-1:0] r_orow, n_orow;
    logic [OUT_RC_W-1:0] r_ocol, n_ocol;
    logic                r_last, n_last;
    logic [Q_W-1:0]      r_acc, n_acc;
    logic                r_rd_vld, n_rd_vld;
    logic                r_out_vld, n_out_vld;
    logic [Q_W-1:0]      r_pooled, n_pooled;
    logic [OUT_RC_W-1:0] r_out_row, n_out_row;
    logic [OUT_RC_W-1:0] r_out_col, n_out_col;
    logic [OUT_CH_W-1:0] r_out_ch, n_out_ch;
    logic                r_final, n_final;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [Q_W-1:0]      ram_rdata;
    logic [2:0]          wm1;
    logic [4:0]          rs_sum;
    logic [SLOT_FW-1:0]  rs0, rs_inc;
    logic [COL_FW-1:0]   c0;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_FW-1:0] rs,
                                                  input logic [COL_FW-1:0] col,
                                                  input logic [CHAN_FW-1:0] ch);
        return ADDR_W'((32'(rs) * MAX_COLS + 32'(col)) * MAX_CHANNELS + 32'(ch));
    endfunction

    mp2d_ram #(
        .WIDTH (Q_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_job.sample),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        wm1    = i_cfg.win - 3'd1;
        rs_sum = 5'(i_job.slot) + 5'(MAX_WINDOW) - 5'(wm1);
        rs0    = (32'(rs_sum) >= MAX_WINDOW) ? SLOT_FW'(32'(rs_sum) - MAX_WINDOW)
                                             : SLOT_FW'(rs_sum);
        rs_inc = (32'(r_rs) + 1 == MAX_WINDOW) ? '0 : r_rs + SLOT_FW'(1);
        c0     = i_job.col + COL_FW'(1) - COL_FW'(i_cfg.win);

        n_state   = r_state;
        n_rs      = r_rs;
        n_cc      = r_cc;
        n_c0      = r_c0;
        n_dr      = r_dr;
        n_dc      = r_dc;
        n_ch      = r_ch;
        n_orow    = r_orow;
        n_ocol    = r_ocol;
        n_last    = r_last;
        n_rd_vld  = 1'b0;
        n_acc     = (r_rd_vld && ($signed(ram_rdata) > $signed(r_acc))) ? ram_rdata : r_acc;
        n_out_vld = r_out_vld && !i_ready;
        n_pooled  = r_pooled;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_out_ch  = r_out_ch;
        n_final   = r_final;
        ram_we    = 1'b0;
        ram_addr  = addr_of(r_rs, r_cc, r_ch);
        o_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    ram_we   = 1'b1;
                    ram_addr = addr_of(i_job.slot, i_job.col, i_job.chan);
                    if (i_job.fire) begin
                        n_state = S_READ;
                        n_rs    = rs0;
                        n_cc    = c0;
                        n_c0    = c0;
                        n_dr    = 3'd0;
                        n_dc    = 3'd0;
                        n_acc   = Q_MIN;
                        n_ch    = i_job.chan;
                        n_orow  = i_job.orow;
                        n_ocol  = i_job.ocol;
                        n_last  = i_job.last;
                    end
                end
            end
            S_READ: begin
                n_rd_vld = 1'b1;
                if (r_dc == wm1) begin
                    n_dc = 3'd0;
                    n_cc = r_c0;
                    n_dr = r_dr + 3'd1;
                    n_rs = rs_inc;
                    if (r_dr == wm1) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_dc = r_dc + 3'd1;
                    n_cc = r_cc + COL_FW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld = 1'b1;
                    n_pooled  = r_acc;
                    n_out_row = r_orow;
                    n_out_col = r_ocol;
                    n_out_ch  = r_ch[OUT_CH_W-1:0];
                    n_final   = r_last;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_rs      <= n_rs;
        r_cc      <= n_cc;
        r_c0      <= n_c0;
        r_dr      <= n_dr;
        r_dc      <= n_dc;
        r_ch      <= n_ch;
        r_orow    <= n_orow;
        r_ocol    <= n_ocol;
        r_last    <= n_last;
        r_acc     <= n_acc;
        r_pooled  <= n_pooled;
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
        r_out_ch  <= n_out_ch;
        r_final   <= n_final;
    end

    assign o_valid         = r_out_vld;
    assign o_pooled        = r_pooled;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_channel_index = r_out_ch;
    assign o_final_res     = r_final;

`ifndef SYNTHESIS
    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_rd_vld) else $error("window sweep lost last read");
    a_sweep_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_dr <= wm1 && r_dc <= wm1))
        else $error("window sweep out of range");
`endif
endmodule
`default_nettype wire

>>> rtl/max_pool_2d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2d - streaming strided 2-D max pooling
// Register file, limit saturation, front/queue/back assembly.
// ----------------------------------------------------------------------------
// Input requests carry one signed Q8.8 tensor element on i_sample, in row,
// column, channel order, under i_valid/o_ready. Results (window maximum,
// output row/column, channel, final flag) leave under o_valid/i_ready.
// Registers are written through i_cfg_wr_en/i_cfg_index/i_cfg_wdata; unknown
// indexes are dropped, out-of-range values are saturated when used.
// A request that completes no window only writes its element to the line store.
// A completing request writes its element, then reads window_size squared
// entries through the single line store port, drains the last read and
// hands the maximum to the output register. Until then the sequencer takes
// no new request from the queue.
// Reset zeroes the position counters and loads the register defaults;
// the line store is not cleared and needs no clearing pass.
// When the receiver stalls, the held result stays on the outputs, the
// sequencer finishes at most one more window, the two-entry queue fills
// and o_ready then drops.
// ----------------------------------------------------------------------------
module max_pool_2d #(
    parameter int MAX_COLS     = mp2d_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = mp2d_pkg::DEF_MAX_ROWS,
    parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = mp2d_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [mp2d_pkg::Q_W-1:0]          i_sample,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [mp2d_pkg::Q_W-1:0]               o_pooled,
    output logic [mp2d_pkg::OUT_RC_W-1:0]          o_out_row,
    output logic [mp2d_pkg::OUT_RC_W-1:0]          o_out_col,
    output logic [mp2d_pkg::OUT_CH_W-1:0]          o_channel_index,
    output logic                                   o_final_res
);
    import mp2d_pkg::*;

    localparam int WIN_CAP = (MAX_WINDOW < 4) ? MAX_WINDOW : 4;

    logic [2:0] r_stride;
    logic [2:0] r_window;
    logic [6:0] r_rows;
    logic [6:0] r_cols;
    logic [4:0] r_chans;

    t_cfg             cfg;
    logic [LIM_W-1:0] rows_x, cols_x, chans_x;
    t_job             fq_job, qb_job;
    logic             fq_push, q_full, q_empty, qb_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= 3'd2;
            r_window <= 3'd2;
            r_rows   <= 7'd64;
            r_cols   <= 7'd64;
            r_chans  <= 5'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_STRIDE: r_stride <= i_cfg_wdata[2:0];
                REG_WINDOW: r_window <= i_cfg_wdata[2:0];
                REG_ROWS:   r_rows   <= i_cfg_wdata;
                REG_COLS:   r_cols   <= i_cfg_wdata;
                REG_CHANS:  r_chans  <= i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rows_x  = LIM_W'(r_rows);
        cols_x  = LIM_W'(r_cols);
        chans_x = LIM_W'(r_chans);

        cfg.stride = (r_stride == 3'd0) ? 3'd1 : ((r_stride > 3'd4) ? 3'd4 : r_stride);
        cfg.win    = (r_window == 3'd0) ? 3'd1
                   : ((32'(r_window) > WIN_CAP) ? 3'(WIN_CAP) : r_window);
        cfg.rows   = (rows_x == '0) ? LIM_W'(1)
                   : ((32'(rows_x) > MAX_ROWS) ? LIM_W'(MAX_ROWS) : rows_x);
        cfg.cols   = (cols_x == '0) ? LIM_W'(1)
                   : ((32'(cols_x) > MAX_COLS) ? LIM_W'(MAX_COLS) : cols_x);
        cfg.chans  = (chans_x == '0) ? LIM_W'(1)
                   : ((32'(chans_x) > MAX_CHANNELS) ? LIM_W'(MAX_CHANNELS) : chans_x);
    end

    mp2d_front #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_full   (q_full),
        .o_push   (fq_push),
        .o_job    (fq_job)
    );

    mp2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_job   (fq_job),
        .o_full  (q_full),
        .i_pop   (qb_pop),
        .o_job   (qb_job),
        .o_empty (q_empty)
    );

    mp2d_back #(
        .MAX_COLS     (MAX_COLS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_job           (qb_job),
        .i_empty         (q_empty),
        .o_pop           (qb_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pooled        (o_pooled),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_channel_index (o_channel_index),
        .o_final_res     (o_final_res)
    );
endmodule
`default_nettype wire

>>> bench/max_pool_2d_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_pool_2d_tb - self-checking bench for the strided 2-D max pooling block
// Streams tensor elements under random pacing on both sides, predicts every
// window maximum with coordinates and final flag, and scoreboards the
// results. The geometry is changed between bursts, tensor boundaries and
// mid-tensor alike, only while the block is idle.
// ----------------------------------------------------------------------------
module max_pool_2d_tb;
    import mp2d_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_WINDOW * DEF_MAX_COLS * DEF_MAX_CHANNELS;
    localparam int SLOT_AW       = $clog2(STORE_DEPTH);
    localparam int WIN_CAP       = (DEF_MAX_WINDOW < 4) ? DEF_MAX_WINDOW : 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_ITEMS  = 1950;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [Q_W-1:0]      pooled;
        logic [OUT_RC_W-1:0] row;
        logic [OUT_RC_W-1:0] col;
        logic [OUT_CH_W-1:0] chan;
        logic                fin;
    } t_pool_result;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic [Q_W-1:0]        in_sample = '0;
    logic                  res_ready = 1'b0;
    wire                   in_ready;
    wire                   res_valid;
    wire [Q_W-1:0]         res_pooled;
    wire [OUT_RC_W-1:0]    res_row;
    wire [OUT_RC_W-1:0]    res_col;
    wire [OUT_CH_W-1:0]    res_chan;
    wire                   res_final;

    // shadow of the block: registers, position counters, line store
    logic [2:0]       reg_stride = 3'd2;
    logic [2:0]       reg_win    = 3'd2;
    logic [6:0]       reg_rows   = 7'd64;
    logic [6:0]       reg_cols   = 7'd64;
    logic [4:0]       reg_chans  = 5'd1;
    logic [5:0]       pos_row    = '0;
    logic [5:0]       pos_col    = '0;
    logic [3:0]       pos_chan   = '0;
    logic [Q_W-1:0]   shadow_store [STORE_DEPTH];

    logic [Q_W-1:0]   sample_backlog [$];
    t_pool_result     pooled_due [$];

    int  in_issued    = 0;
    int  in_accepted  = 0;
    int  err_count    = 0;
    int  quiet_cycles = 0;
    int  tx_wait      = 0;
    int  rx_wait      = 0;
    bit  tx_burst     = 1'b0;
    bit  rx_burst     = 1'b0;
    bit  in_taken     = 1'b0;
    bit  out_taken    = 1'b0;

    max_pool_2d dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_sample        (in_sample),
        .o_valid         (res_valid),
        .i_ready         (res_ready),
        .o_pooled        (res_pooled),
        .o_out_row       (res_row),
        .o_out_col       (res_col),
        .o_channel_index (res_chan),
        .o_final_res     (res_final)
    );

    always #5 clk = ~clk;

    function automatic int clampi(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_stride();
        return clampi(int'(reg_stride), 1, 4);
    endfunction

    function automatic int eff_win();
        return clampi(int'(reg_win), 1, WIN_CAP);
    endfunction

    function automatic int eff_rows();
        return clampi(int'(reg_rows), 1, DEF_MAX_ROWS);
    endfunction

    function automatic int eff_cols();
        return clampi(int'(reg_cols), 1, DEF_MAX_COLS);
    endfunction

    function automatic int eff_chans();
        return clampi(int'(reg_chans), 1, DEF_MAX_CHANNELS);
    endfunction

    function automatic logic [SLOT_AW-1:0] store_slot(input int r, input int c, input int ch);
        return SLOT_AW'(((r % DEF_MAX_WINDOW) * DEF_MAX_COLS + (c % DEF_MAX_COLS))
                        * DEF_MAX_CHANNELS + (ch % DEF_MAX_CHANNELS));
    endfunction

    // store the element, emit the window maximum if it closes a window, advance
    function automatic void window_max_step(input logic [Q_W-1:0] smp);
        int                    s, w, rows, cols, chans, r, c, ch, orow, ocol;
        logic signed [Q_W-1:0] best, v;
        t_pool_result          res;
        s     = eff_stride();
        w     = eff_win();
        rows  = eff_rows();
        cols  = eff_cols();
        chans = eff_chans();
        r     = int'(pos_row);
        c     = int'(pos_col);
        ch    = int'(pos_chan);
        shadow_store[store_slot(r, c, ch)] = smp;
        if (r + 1 >= w && c + 1 >= w && (r + 1 - w) % s == 0 && (c + 1 - w) % s == 0) begin
            best = Q_MIN;
            for (int dr = 0; dr < w; dr++) begin
                for (int dc = 0; dc < w; dc++) begin
                    v = shadow_store[store_slot(r + 1 - w + dr, c + 1 - w + dc, ch)];
                    if (v > best) best = v;
                end
            end
            orow       = (r + 1 - w) / s;
            ocol       = (c + 1 - w) / s;
            res.pooled = best;
            res.row    = orow[OUT_RC_W-1:0];
            res.col    = ocol[OUT_RC_W-1:0];
            res.chan   = ch[OUT_CH_W-1:0];
            res.fin    = rows >= w && cols >= w && orow == (rows - w) / s
                         && ocol == (cols - w) / s && ch + 1 == chans;
            pooled_due.push_back(res);
        end
        if (ch + 1 >= chans) begin
            pos_chan = '0;
            if (c + 1 >= cols) begin
                pos_col = '0;
                pos_row = (r + 1 >= rows) ? '0 : 6'(r + 1);
            end else begin
                pos_col = 6'(c + 1);
            end
        end else begin
            pos_chan = 4'(ch + 1);
        end
    endfunction

    function automatic int pace(input bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [Q_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return ~Q_MIN;
            2: return Q_W'($urandom_range(0, 8)) - Q_W'(4);
            default: return Q_W'($urandom);
        endcase
    endfunction

    task automatic report(input string what, input logic [Q_W-1:0] got,
                          input logic [Q_W-1:0] want);
        err_count++;
        $display("%0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic check_result();
        t_pool_result want;
        if (pooled_due.size() == 0) begin
            report("result with none due, pooled", res_pooled, '0);
        end else begin
            want = pooled_due.pop_front();
            if (res_pooled !== want.pooled) report("pooled", res_pooled, want.pooled);
            if (res_row !== want.row)       report("out_row", Q_W'(res_row), Q_W'(want.row));
            if (res_col !== want.col)       report("out_col", Q_W'(res_col), Q_W'(want.col));
            if (res_chan !== want.chan)     report("channel", Q_W'(res_chan), Q_W'(want.chan));
            if (res_final !== want.fin)     report("final", Q_W'(res_final), Q_W'(want.fin));
        end
    endtask

    always @(posedge clk) begin
        in_taken  <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && res_valid && res_ready;
        if (rst_n && in_valid && in_ready) begin
            window_max_step(in_sample);
            in_accepted <= in_accepted + 1;
        end
        if (rst_n && res_valid && res_ready) check_result();
    end

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (tx_wait != 0) begin
                in_valid <= 1'b0;
                tx_wait  <= tx_wait - 1;
            end else if (sample_backlog.size() != 0) begin
                in_valid  <= 1'b1;
                in_sample <= sample_backlog.pop_front();
                if ($urandom_range(0, 63) == 0) tx_burst <= !tx_burst;
                tx_wait   <= pace(tx_burst);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge clk) begin : rx_pace
        int g;
        g = rx_wait;
        if (out_taken) begin
            if ($urandom_range(0, 63) == 0) rx_burst <= !rx_burst;
            g = pace(rx_burst);
        end
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (g != 0) begin
            res_ready <= 1'b0;
            rx_wait   <= g - 1;
        end else begin
            res_ready <= 1'b1;
            rx_wait   <= 0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (res_valid && res_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STRIDE: reg_stride = val[2:0];
            REG_WINDOW: reg_win    = val[2:0];
            REG_ROWS:   reg_rows   = val[6:0];
            REG_COLS:   reg_cols   = val[6:0];
            REG_CHANS:  reg_chans  = val[4:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic issue(input logic [Q_W-1:0] smp);
        sample_backlog.push_back(smp);
        in_issued++;
    endtask

    // hold off until every request is in and every result out, then let the
    // block finish any window-less requests still queued
    task automatic settle();
        while (in_accepted != in_issued || pooled_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_value(input int idx);
        case (idx)
            REG_STRIDE, REG_WINDOW:
                return ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                                   : CFG_DATA_W'($urandom_range(1, 4));
            REG_ROWS, REG_COLS:
                case ($urandom_range(0, 15))
                    0: return '0;
                    1: return 7'd64;
                    2: return CFG_DATA_W'($urandom_range(65, 127));
                    default: return CFG_DATA_W'($urandom_range(1, 10));
                endcase
            default:
                case ($urandom_range(0, 15))
                    0: return '0;
                    1: return 7'd16;
                    2: return CFG_DATA_W'($urandom_range(17, 31));
                    default: return CFG_DATA_W'($urandom_range(1, 4));
                endcase
        endcase
    endfunction

    // mid-tensor, widening the column or channel span would expose store
    // entries never written, so only narrowing is allowed there
    task automatic pick_config();
        bit                    mid;
        int                    old_cols, old_chans;
        logic [CFG_DATA_W-1:0] v;
        mid       = (pos_row != 0 || pos_col != 0 || pos_chan != 0);
        old_cols  = eff_cols();
        old_chans = eff_chans();
        for (int k = int'(REG_STRIDE); k <= int'(REG_CHANS); k++) begin
            if ($urandom_range(0, 1) == 0) continue;
            v = pick_value(k);
            if (mid && k == REG_COLS && clampi(int'(v), 1, DEF_MAX_COLS) > old_cols) continue;
            if (mid && k == REG_CHANS && clampi(int'(v), 1, DEF_MAX_CHANNELS) > old_chans)
                continue;
            cfg_write(CFG_IDX_W'(k), v);
        end
        if ($urandom_range(0, 7) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(REG_CHANS + 1, REG_UNUSED)),
                      CFG_DATA_W'($urandom));
        cfg_close();
    endtask

    function automatic int burst_length();
        int tensor, done_so_far, n;
        tensor = eff_rows() * eff_cols() * eff_chans();
        n      = $urandom_range(1, 250);
        if ($urandom_range(0, 1) && pos_row < eff_rows() && pos_col < eff_cols()
            && pos_chan < eff_chans()) begin
            done_so_far = (pos_row * eff_cols() + pos_col) * eff_chans() + pos_chan;
            if (tensor - done_so_far + 2 * tensor <= 400)
                n = tensor - done_so_far + tensor * $urandom_range(0, 2);
        end
        return n;
    endfunction

    initial begin : stimulus
        int total, n;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // 1x2x2 tensor with a 1x1 window: every request yields its own value
        cfg_write(REG_STRIDE, 7'd1);
        cfg_write(REG_WINDOW, 7'd1);
        cfg_write(REG_ROWS, 7'd1);
        cfg_write(REG_COLS, 7'd2);
        cfg_write(REG_CHANS, 7'd2);
        cfg_close();
        issue(~Q_MIN);
        issue(Q_MIN);
        issue('0);
        issue('1);
        settle();

        // saturated registers, unknown index, window larger than the tensor
        cfg_write(REG_STRIDE, 7'd0);
        cfg_write(REG_WINDOW, 7'd7);
        cfg_write(REG_ROWS, 7'd3);
        cfg_write(REG_COLS, 7'd3);
        cfg_write(REG_CHANS, 7'd0);
        cfg_write(REG_UNUSED, 7'h7F);
        cfg_close();
        for (int i = 0; i < 9; i++) issue(rand_sample());
        settle();

        // 2x2 stride 2 on 3x3: partial edge windows, a single final result
        cfg_write(REG_STRIDE, 7'd2);
        cfg_write(REG_WINDOW, 7'd2);
        cfg_close();
        for (int i = 0; i < 9; i++) issue(rand_sample());
        settle();

        total = 0;
        while (total < RANDOM_ITEMS) begin
            pick_config();
            n = burst_length();
            for (int i = 0; i < n; i++) issue(rand_sample());
            total += n;
            settle();
        end

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mp2d_pkg.sv
rtl/mp2d_ram.sv
rtl/mp2d_queue.sv
rtl/mp2d_front.sv
rtl/mp2d_back.sv
rtl/max_pool_2d.sv
bench/max_pool_2d_tb.sv
